// ----- hdl/anbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Annex B NAL splitter package
// Record and entry types passed from the framing front end, through the
// record queue, to the unit back end, and the byte and type constants.
// ----------------------------------------------------------------------------
package anbs_pkg;

  localparam int unsigned RecsPerEntry = 4;

  localparam logic [7:0] ZeroByte      = 8'h00;
  localparam logic [7:0] StartCodeTail = 8'h01;

  localparam logic [4:0] NalTypeSps = 5'd7;
  localparam logic [4:0] NalTypePps = 5'd8;

  localparam logic [2:0] PosMax     = 3'd7;
  localparam logic [2:0] ProfileEnd = 3'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] pos;
  } rec_t;

  typedef struct packed {
    rec_t [RecsPerEntry-1:0] recs;
    logic [1:0]              last_idx;
  } entry_t;

endpackage

// ----- hdl/anbs_front.sv -----
// ----------------------------------------------------------------------------
// Annex B NAL splitter front end
// Tracks start codes and withheld zero bytes, and turns each accepted stream
// byte into a queue entry of up to four unit byte records.
// ----------------------------------------------------------------------------
module anbs_front import anbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_value_i,
  input  logic       end_of_buffer_i,
  output logic       push_o,
  output entry_t     entry_o
);

  logic       inside_q, inside_d;
  logic [1:0] count_q, count_d;
  logic       lead_q, lead_d;
  logic [7:0] lead_byte_q, lead_byte_d;
  logic [2:0] pos_q, pos_d;

  logic       mid_lead;
  logic [7:0] mid_byte;
  logic       pos_reset;
  logic       a_last;
  logic [1:0] zr;
  logic [2:0] a_n, b_n, n, j, kk;
  logic [3:0] pos_sum, pos_next;

  always_comb begin
    inside_d    = inside_q;
    count_d     = count_q;
    lead_d      = lead_q;
    lead_byte_d = lead_byte_q;
    pos_reset   = 1'b0;
    a_n         = 3'd0;
    a_last      = 1'b0;
    b_n         = 3'd0;
    zr          = count_q - {1'b0, lead_q};
    if (!inside_q) begin
      if (byte_value_i == ZeroByte) begin
        count_d = (count_q < 2'd2) ? count_q + 2'd1 : count_q;
        lead_d  = 1'b0;
      end else if (byte_value_i == StartCodeTail && count_q >= 2'd2) begin
        inside_d  = 1'b1;
        count_d   = 2'd0;
        lead_d    = 1'b0;
        pos_reset = 1'b1;
      end else begin
        count_d = 2'd0;
      end
    end else begin
      if (byte_value_i == ZeroByte) begin
        if (zr >= 2'd2) begin
          a_n      = {2'b00, lead_q};
          a_last   = 1'b1;
          inside_d = 1'b0;
          count_d  = 2'd2;
          lead_d   = 1'b0;
        end else if (count_q < 2'd3) begin
          count_d = count_q + 2'd1;
        end
      end else if (byte_value_i == StartCodeTail && zr >= 2'd2) begin
        a_n       = {2'b00, lead_q};
        a_last    = 1'b1;
        pos_reset = 1'b1;
        count_d   = 2'd0;
        lead_d    = 1'b0;
      end else begin
        a_n         = {1'b0, count_q};
        lead_byte_d = byte_value_i;
        count_d     = 2'd1;
        lead_d      = 1'b1;
      end
    end
    mid_lead = lead_d;
    mid_byte = lead_byte_d;
    if (end_of_buffer_i) begin
      if (inside_d) begin
        b_n = {1'b0, count_d};
      end
      inside_d = 1'b0;
      count_d  = 2'd0;
      lead_d   = 1'b0;
    end
    n = a_n + b_n;

    j  = 3'd0;
    kk = 3'd0;
    for (int k = 0; k < RecsPerEntry; k++) begin
      kk = 3'(k);
      if (kk < a_n) begin
        entry_o.recs[k].data = (k == 0 && lead_q) ? lead_byte_q : ZeroByte;
        entry_o.recs[k].last = a_last;
      end else begin
        j = kk - a_n;
        entry_o.recs[k].data = (j == 3'd0 && mid_lead) ? mid_byte : ZeroByte;
        entry_o.recs[k].last = (j == b_n - 3'd1);
      end
      pos_sum = {1'b0, pos_q} + 4'(k);
      entry_o.recs[k].pos = pos_sum[3] ? PosMax : pos_sum[2:0];
    end
    entry_o.last_idx = 2'(n - 3'd1);

    pos_next = {1'b0, pos_q} + {1'b0, n};
    if (pos_reset) begin
      pos_d = 3'd0;
    end else begin
      pos_d = pos_next[3] ? PosMax : pos_next[2:0];
    end
  end

  assign push_o = accept_i && (n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q    <= 1'b0;
      count_q     <= 2'd0;
      lead_q      <= 1'b0;
      lead_byte_q <= 8'd0;
      pos_q       <= 3'd0;
    end else if (accept_i) begin
      inside_q    <= inside_d;
      count_q     <= count_d;
      lead_q      <= lead_d;
      lead_byte_q <= lead_byte_d;
      pos_q       <= pos_d;
    end
  end

endmodule

// ----- hdl/anbs_queue.sv -----
// ----------------------------------------------------------------------------
// Annex B NAL splitter record queue
// A short first-in first-out store of entries between the front end and the
// back end, so that either side may stall without holding up the other.
// ----------------------------------------------------------------------------
module anbs_queue import anbs_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/anbs_back.sv -----
// ----------------------------------------------------------------------------
// Annex B NAL splitter back end
// Drains queued records one per cycle unless pop stalls, tracks the unit
// type, parameter set flags and profile word, and holds the result in a register.
// ----------------------------------------------------------------------------
module anbs_back import anbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  entry_t      head_i,
  output logic        head_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [7:0]  unit_byte_o,
  output logic        unit_first_o,
  output logic        unit_last_o,
  output logic [4:0]  unit_type_o,
  output logic        params_ready_o,
  output logic [23:0] profile_level_o,
  output logic        run_last_o
);

  logic [1:0]  idx_q;
  logic [4:0]  type_q, type_d;
  logic [23:0] profile_q, profile_d;
  logic        sps_q, sps_d, pps_q, pps_d;
  logic        out_valid_q;
  logic        take, first, run_last;
  rec_t        rec;

  assign take       = head_valid_i && (!out_valid_q || pop_i);
  assign rec        = head_i.recs[idx_q];
  assign first      = (rec.pos == 3'd0);
  assign run_last   = (idx_q == head_i.last_idx);
  assign head_pop_o = take && run_last;
  assign empty_o    = !out_valid_q;

  always_comb begin
    type_d    = type_q;
    profile_d = profile_q;
    sps_d     = sps_q;
    pps_d     = pps_q;
    if (first) begin
      type_d = rec.data[4:0];
      if (type_d == NalTypeSps) begin
        sps_d     = 1'b1;
        profile_d = 24'd0;
      end
      if (type_d == NalTypePps) begin
        pps_d = 1'b1;
      end
    end else if (type_q == NalTypeSps && rec.pos <= ProfileEnd) begin
      profile_d = {profile_q[15:0], rec.data};
    end
    if (rec.last && type_d == NalTypeSps && rec.pos < ProfileEnd) begin
      profile_d = 24'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      type_q      <= 5'd0;
      profile_q   <= 24'd0;
      sps_q       <= 1'b0;
      pps_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        idx_q       <= run_last ? 2'd0 : idx_q + 2'd1;
        type_q      <= type_d;
        profile_q   <= profile_d;
        sps_q       <= sps_d;
        pps_q       <= pps_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      unit_byte_o     <= rec.data;
      unit_first_o    <= first;
      unit_last_o     <= rec.last;
      unit_type_o     <= type_d;
      params_ready_o  <= sps_d && pps_d;
      profile_level_o <= profile_d;
      run_last_o      <= run_last;
    end
  end

endmodule

// ----- hdl/annexb_nal_splitter_core.sv -----
// ----------------------------------------------------------------------------
// Annex B NAL splitter core
// Splits an H.264 Annex B byte stream into NAL unit bytes with first and
// last flags, unit type, parameter set status and the SPS profile word.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Fields
// input     in         push / full         byte_value_i, end_of_buffer_i
// result    out        pop / empty         unit_byte_o .. run_last_o
//
// One stream byte is taken per cycle while the record queue has room.
// Each byte gives zero to four result transactions; the back end delivers
// one result per cycle while the receiver keeps popping, and the queue
// absorbs the difference.
// A stall on pop fills the output register, then the queue, then raises full.
// Reset clears all framing and parameter set state at once; no sweep.
// ----------------------------------------------------------------------------
module annexb_nal_splitter_core import anbs_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_buffer_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  unit_byte_o,
  output logic        unit_first_o,
  output logic        unit_last_o,
  output logic [4:0]  unit_type_o,
  output logic        params_ready_o,
  output logic [23:0] profile_level_o,
  output logic        run_last_o
);

  logic   accept;
  logic   q_push, q_valid, q_pop;
  entry_t q_in, q_out;

  assign accept = push && !full;

  anbs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .byte_value_i    (byte_value_i),
    .end_of_buffer_i (end_of_buffer_i),
    .push_o          (q_push),
    .entry_o         (q_in)
  );

  anbs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  anbs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (q_valid),
    .head_i          (q_out),
    .head_pop_o      (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .unit_byte_o     (unit_byte_o),
    .unit_first_o    (unit_first_o),
    .unit_last_o     (unit_last_o),
    .unit_type_o     (unit_type_o),
    .params_ready_o  (params_ready_o),
    .profile_level_o (profile_level_o),
    .run_last_o      (run_last_o)
  );

`ifndef SYNTH
  first_type_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && unit_first_o) |-> (unit_type_o == unit_byte_o[4:0]))
    else $error("Header byte and unit type disagree.");

  sps_header_clears_profile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && unit_first_o && unit_type_o == NalTypeSps) |-> (profile_level_o == 24'd0))
    else $error("Profile word not cleared on an SPS header.");

  unit_end_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && unit_last_o) |-> run_last_o)
    else $error("A unit ended before the last result of its input byte.");

  no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !full)
    else $error("Front end pushed into a full queue.");
`endif

endmodule

// ----- sim/annexb_nal_splitter_core_tb.sv -----
// ----------------------------------------------------------------------------
// Annex B NAL splitter core testbench
// Sends Annex B byte streams into the splitter one byte per transaction. The
// streams are directed edge cases first, then random well-formed units mixed
// with noise. A predictor class works out the unit bytes that each stream
// byte should release, and checks every popped result against them in order.
// Both sides idle at random. The receiver also stalls long enough to fill
// the core, and the sender waits for the core to drain.
// ----------------------------------------------------------------------------
module annexb_nal_splitter_core_tb;
  import anbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned RandomItems   = 204;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned LongHold      = 300;
  localparam logic [4:0]  NalTypeSlice  = 5'd1;
  localparam logic [4:0]  NalTypeIdr    = 5'd5;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [4:0]  nal_type;
    logic        ready;
    logic [23:0] profile;
    logic        run_last;
  } unit_rec_t;

  class nal_unit_predictor;
    logic [7:0]  held[3];
    int          held_n;
    bit          held_data;
    bit          in_unit;
    logic [2:0]  position;
    logic [4:0]  cur_type;
    logic [23:0] profile_word;
    bit          sps_seen;
    bit          pps_seen;
    unit_rec_t   step_q[$];
    unit_rec_t   unit_bytes_due[$];
    int          errors;

    function new();
      held_n       = 0;
      held_data    = 0;
      in_unit      = 0;
      position     = '0;
      cur_type     = '0;
      profile_word = '0;
      sps_seen     = 0;
      pps_seen     = 0;
      errors       = 0;
      foreach (held[i]) held[i] = ZeroByte;
    endfunction

    function void release_byte(input logic [7:0] b, input bit last);
      unit_rec_t r;
      bit first;
      if (step_q.size() >= RecsPerEntry) return;
      first = (position == 3'd0);
      if (first) begin
        cur_type = b[4:0];
        if (cur_type == NalTypeSps) begin
          sps_seen     = 1;
          profile_word = '0;
        end
        if (cur_type == NalTypePps) pps_seen = 1;
      end else if (cur_type == NalTypeSps && position <= ProfileEnd) begin
        profile_word = {profile_word[15:0], b};
      end
      if (last && cur_type == NalTypeSps && position < ProfileEnd) profile_word = '0;
      r.data     = b;
      r.first    = first;
      r.last     = last;
      r.nal_type = cur_type;
      r.ready    = sps_seen && pps_seen;
      r.profile  = profile_word;
      r.run_last = 1'b0;
      if (position < PosMax) position++;
      step_q = {step_q, r};
    endfunction

    function void take_stream_byte(input logic [7:0] b, input logic eob);
      int zero_run;
      step_q.delete();
      if (!in_unit) begin
        if (b == ZeroByte) begin
          if (held_n < 2) held_n++;
          held_data = 0;
        end else if (b == StartCodeTail && held_n >= 2) begin
          in_unit   = 1;
          held_n    = 0;
          held_data = 0;
          position  = '0;
        end else begin
          held_n = 0;
        end
      end else begin
        zero_run = held_n - int'(held_data);
        if (b == ZeroByte) begin
          if (zero_run >= 2) begin
            if (held_data) release_byte(held[0], 1);
            in_unit   = 0;
            held_n    = 2;
            held_data = 0;
          end else if (held_n < 3) begin
            held[held_n] = ZeroByte;
            held_n++;
          end
        end else if (b == StartCodeTail && zero_run >= 2) begin
          if (held_data) release_byte(held[0], 1);
          position  = '0;
          held_n    = 0;
          held_data = 0;
        end else begin
          for (int i = 0; i < held_n; i++) release_byte(held[i], 0);
          held[0]   = b;
          held_n    = 1;
          held_data = 1;
        end
      end
      if (eob) begin
        if (in_unit) begin
          for (int i = 0; i < held_n; i++) release_byte(held[i], i + 1 == held_n);
        end
        in_unit   = 0;
        held_n    = 0;
        held_data = 0;
      end
      if (step_q.size() > 0) begin
        step_q[step_q.size() - 1].run_last = 1'b1;
      end
      unit_bytes_due = {unit_bytes_due, step_q};
    endfunction

    function void compare_field(input string name, input logic [23:0] want,
                                input logic [23:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_unit_byte(input unit_rec_t got);
      unit_rec_t want;
      if (unit_bytes_due.size() == 0) begin
        $error("unexpected result transaction: unit_byte %0h", got.data);
        errors++;
        return;
      end
      want = unit_bytes_due.pop_front();
      compare_field("unit_byte", want.data, got.data);
      compare_field("unit_first", want.first, got.first);
      compare_field("unit_last", want.last, got.last);
      compare_field("unit_type", want.nal_type, got.nal_type);
      compare_field("params_ready", want.ready, got.ready);
      compare_field("profile_level", want.profile, got.profile);
      compare_field("run_last", want.run_last, got.run_last);
    endfunction

    function int pending();
      return unit_bytes_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  byte_value_i;
  logic        end_of_buffer_i;
  logic        empty;
  logic        pop;
  logic [7:0]  unit_byte_o;
  logic        unit_first_o;
  logic        unit_last_o;
  logic [4:0]  unit_type_o;
  logic        params_ready_o;
  logic [23:0] profile_level_o;
  logic        run_last_o;

  nal_unit_predictor predictor;
  int unsigned       cycle_count;
  int                hold_cycles = 0;
  bit                tx_idle = 1;
  bit                rx_idle = 1;
  int                random_sent = 0;

  annexb_nal_splitter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .byte_value_i    (byte_value_i),
    .end_of_buffer_i (end_of_buffer_i),
    .empty           (empty),
    .pop             (pop),
    .unit_byte_o     (unit_byte_o),
    .unit_first_o    (unit_first_o),
    .unit_last_o     (unit_last_o),
    .unit_type_o     (unit_type_o),
    .params_ready_o  (params_ready_o),
    .profile_level_o (profile_level_o),
    .run_last_o      (run_last_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) predictor.take_stream_byte(byte_value_i, end_of_buffer_i);
      if (pop && !empty) begin
        predictor.check_unit_byte(unit_rec_t'{unit_byte_o, unit_first_o, unit_last_o,
                                              unit_type_o, params_ready_o,
                                              profile_level_o, run_last_o});
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random gaps between pops, plus one long hold when requested.
  initial begin
    int idle_for;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      idle_for    = hold_cycles + (rx_idle ? $urandom_range(0, 6) : 0);
      hold_cycles = 0;
      if (idle_for > 0) begin
        pop <= 1'b0;
        repeat (idle_for) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push            <= 1'b1;
    byte_value_i    <= b;
    end_of_buffer_i <= eob;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_start(input bit four_byte, input logic eob);
    if (four_byte) send_byte(ZeroByte, 1'b0);
    send_byte(ZeroByte, 1'b0);
    send_byte(ZeroByte, 1'b0);
    send_byte(StartCodeTail, eob);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (predictor.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_unit();
    int          len;
    bit          ends_buffer;
    bit          four_byte;
    logic [4:0]  nal_type;
    logic [7:0]  b;
    four_byte = ($urandom_range(0, 3) == 0);
    send_start(four_byte, 1'b0);
    case ($urandom_range(0, 5))
      0:       nal_type = NalTypeSps;
      1:       nal_type = NalTypePps;
      2:       nal_type = NalTypeIdr;
      3:       nal_type = NalTypeSlice;
      default: nal_type = 5'($urandom_range(0, 31));
    endcase
    len         = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
    ends_buffer = ($urandom_range(0, 3) == 0);
    send_byte({3'($urandom_range(0, 7)), nal_type}, len == 0 && ends_buffer);
    random_sent += four_byte ? 5 : 4;
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(0, 3) == 0) ? ZeroByte : 8'($urandom_range(1, 255));
      send_byte(b, i == len - 1 && ends_buffer);
      random_sent++;
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat (3) send_byte(ZeroByte, 1'b0);
      random_sent += 3;
    end
  endtask

  task automatic send_noise();
    int   count;
    logic [7:0] b;
    count = $urandom_range(1, 4);
    for (int i = 0; i < count; i++) begin
      b = ($urandom_range(0, 2) == 0) ? ZeroByte : 8'($urandom_range(0, 255));
      send_byte(b, $urandom_range(0, 7) == 0);
      random_sent++;
    end
  endtask

  initial begin
    bit paused;
    predictor       = new();
    rst_ni          = 1'b0;
    push            = 1'b0;
    byte_value_i    = '0;
    end_of_buffer_i = 1'b0;
    paused          = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Junk before the first start code, then a full SPS.
    send_byte(8'hFF, 1'b0);
    send_start(0, 1'b0);
    send_byte(8'h67, 1'b0);
    send_byte(8'h64, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h2A, 1'b0);
    // A four-byte start code ends the SPS on its zero run; a PPS follows.
    send_start(1, 1'b0);
    send_byte(8'h68, 1'b0);
    // An empty unit, then a short SPS cut by a start code at buffer end.
    send_start(0, 1'b0);
    send_start(0, 1'b0);
    send_byte(8'h67, 1'b0);
    send_byte(8'h42, 1'b0);
    send_start(0, 1'b1);
    // Zero header byte, and a buffer end releasing four bytes at once.
    send_start(0, 1'b0);
    send_byte(ZeroByte, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(ZeroByte, 1'b0);
    send_byte(ZeroByte, 1'b0);
    send_byte(8'hAA, 1'b1);

    // The receiver holds off while a long unit is pushed back to back.
    tx_idle     = 0;
    hold_cycles = LongHold;
    send_start(0, 1'b0);
    send_byte(8'h41, 1'b0);
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(2, 255)), i == 39);
    wait_drained();
    tx_idle = 1;

    while (random_sent < RandomItems) begin
      if (!paused && random_sent > RandomItems / 2) begin
        wait_drained();
        paused = 1;
      end
      if ($urandom_range(0, 5) == 0) tx_idle = !tx_idle;
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_random_unit();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (predictor.errors == 0 && predictor.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
